/* hdl/wdt_pkg.sv */
package wdt_pkg;

    localparam int unsigned CountWidth = 15;
    localparam logic [7:0] CLEAR_KEY = 8'hA5;
    localparam logic [3:0] CODE_RESET = 4'hB;
    localparam logic [3:0] CODE_SATURATE = 4'hB;
    localparam logic [CountWidth-1:0] MAX_CYCLES = 15'd16384;
    localparam logic [CountWidth-1:0] BASE_CYCLES = 15'd8;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        SEL_CTRL     = 3'd0,
        SEL_PERIOD   = 3'd1,
        SEL_EWOFFSET = 3'd2,
        SEL_INTSET   = 3'd3,
        SEL_INTCLR   = 3'd4,
        SEL_FLAG     = 3'd5,
        SEL_STATUS   = 3'd6,
        SEL_CLEAR    = 3'd7
    } t_sel;

    typedef struct packed {
        logic [1:0] operation;
        logic [2:0] reg_select;
        logic [7:0] write_data;
    } t_req;

    typedef struct packed {
        logic [7:0] read_data;
        logic       early_warning_irq;
        logic       system_reset;
    } t_rsp;

    // Period and offset codes: 8 << code, saturating for the upper codes
    function automatic logic [CountWidth-1:0] code_to_cycles(input logic [3:0] code);
        logic [CountWidth-1:0] cycles;
        if (code >= CODE_SATURATE) begin
            cycles = MAX_CYCLES;
        end else begin
            cycles = BASE_CYCLES << code;
        end
        return cycles;
    endfunction

endpackage

/* hdl/wdt_req_if.sv */
interface wdt_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [2:0] reg_select;
    logic [7:0] write_data;

    modport source (output valid, output operation, output reg_select, output write_data,
                    input ready);
    modport sink (input valid, input operation, input reg_select, input write_data,
                  output ready);
endinterface

/* hdl/wdt_rsp_if.sv */
interface wdt_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       early_warning_irq;
    logic       system_reset;

    modport source (output valid, output read_data, output early_warning_irq,
                    output system_reset, input ready);
    modport sink (input valid, input read_data, input early_warning_irq,
                  input system_reset, output ready);
endinterface

/* hdl/wdt_core.sv */
module wdt_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_fire,
    input  wdt_pkg::t_req i_req,
    output wdt_pkg::t_rsp o_rsp
);

    logic                           r_run_enable;
    logic                           r_window_enable;
    logic [3:0]                     r_period_code;
    logic [3:0]                     r_warning_code;
    logic                           r_warning_int_enable;
    logic                           r_warning_flag;
    logic [wdt_pkg::CountWidth-1:0] r_tick_count;

    logic                           n_run_enable;
    logic                           n_window_enable;
    logic [3:0]                     n_period_code;
    logic [3:0]                     n_warning_code;
    logic                           n_warning_int_enable;
    logic                           n_warning_flag;
    logic [wdt_pkg::CountWidth-1:0] n_tick_count;

    logic [wdt_pkg::CountWidth-1:0] count_inc;
    logic [7:0]                     read_data;
    logic                           system_reset;

    assign count_inc = r_tick_count + 1'b1;

    always_comb begin
        n_run_enable         = r_run_enable;
        n_window_enable      = r_window_enable;
        n_period_code        = r_period_code;
        n_warning_code       = r_warning_code;
        n_warning_int_enable = r_warning_int_enable;
        n_warning_flag       = r_warning_flag;
        n_tick_count         = r_tick_count;
        read_data            = '0;
        system_reset         = 1'b0;

        unique case (wdt_pkg::t_op'(i_req.operation))
            wdt_pkg::OP_TICK: begin
                if (r_run_enable) begin
                    n_tick_count = count_inc;
                    if (count_inc == wdt_pkg::code_to_cycles(r_warning_code)) begin
                        n_warning_flag = 1'b1;
                    end
                    if (count_inc >= wdt_pkg::code_to_cycles(r_period_code)) begin
                        system_reset = 1'b1;
                        n_tick_count = '0;
                    end
                end
            end
            wdt_pkg::OP_WRITE: begin
                unique case (wdt_pkg::t_sel'(i_req.reg_select))
                    wdt_pkg::SEL_CTRL: begin
                        n_run_enable    = i_req.write_data[0];
                        n_window_enable = i_req.write_data[1];
                    end
                    wdt_pkg::SEL_PERIOD:   n_period_code  = i_req.write_data[3:0];
                    wdt_pkg::SEL_EWOFFSET: n_warning_code = i_req.write_data[3:0];
                    wdt_pkg::SEL_INTSET: begin
                        if (i_req.write_data[0]) n_warning_int_enable = 1'b1;
                    end
                    wdt_pkg::SEL_INTCLR: begin
                        if (i_req.write_data[0]) n_warning_int_enable = 1'b0;
                    end
                    wdt_pkg::SEL_FLAG: begin
                        if (i_req.write_data[0]) n_warning_flag = 1'b0;
                    end
                    wdt_pkg::SEL_STATUS: begin
                    end
                    wdt_pkg::SEL_CLEAR: begin
                        if (i_req.write_data == wdt_pkg::CLEAR_KEY) n_tick_count = '0;
                    end
                endcase
            end
            wdt_pkg::OP_READ: begin
                unique case (wdt_pkg::t_sel'(i_req.reg_select))
                    wdt_pkg::SEL_CTRL:     read_data = {6'd0, r_window_enable, r_run_enable};
                    wdt_pkg::SEL_PERIOD:   read_data = {4'd0, r_period_code};
                    wdt_pkg::SEL_EWOFFSET: read_data = {4'd0, r_warning_code};
                    wdt_pkg::SEL_INTSET,
                    wdt_pkg::SEL_INTCLR:   read_data = {7'd0, r_warning_int_enable};
                    wdt_pkg::SEL_FLAG:     read_data = {7'd0, r_warning_flag};
                    wdt_pkg::SEL_STATUS,
                    wdt_pkg::SEL_CLEAR:    read_data = '0;
                endcase
            end
            default: begin
                // undefined operation: no action
            end
        endcase

        o_rsp.read_data         = read_data;
        o_rsp.early_warning_irq = n_warning_flag & n_warning_int_enable;
        o_rsp.system_reset      = system_reset;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_enable         <= 1'b0;
            r_window_enable      <= 1'b0;
            r_period_code        <= wdt_pkg::CODE_RESET;
            r_warning_code       <= wdt_pkg::CODE_RESET;
            r_warning_int_enable <= 1'b0;
            r_warning_flag       <= 1'b0;
            r_tick_count         <= '0;
        end else if (i_fire) begin
            r_run_enable         <= n_run_enable;
            r_window_enable      <= n_window_enable;
            r_period_code        <= n_period_code;
            r_warning_code       <= n_warning_code;
            r_warning_int_enable <= n_warning_int_enable;
            r_warning_flag       <= n_warning_flag;
            r_tick_count         <= n_tick_count;
        end
    end

endmodule

/* hdl/watchdog_timer_early_warning.sv */
// Watchdog timer with early-warning interrupt.
//
// i_req carries one request per handshake: a slow-clock tick, a register
// write or a register read (operation, reg_select, write_data). o_rsp
// returns exactly one response per request: read_data (zero unless a
// read), early_warning_irq (flag and interrupt enable after the request)
// and system_reset (high on the tick where the count reaches or passes the period).
//
// An accepted request is captured in the input register, evaluated
// against the watchdog state as it advances and presented on o_rsp from
// the output register. Throughput: one request per cycle while o_rsp
// does not stall, with the state updated between the two registers.
//
// Reset (i_rst_n low, synchronous) stops the counter, sets both codes to
// 11 (16384 ticks), clears the flag, interrupt enable and count, and
// empties both pipeline registers. When o_rsp stalls, the response holds,
// one further request is held in the input register, and i_req.ready
// drops until the response is taken.
module watchdog_timer_early_warning (
    input  logic        i_clk,
    input  logic        i_rst_n,
    wdt_req_if.sink     i_req,
    wdt_rsp_if.source   o_rsp
);

    logic          r_in_valid;
    wdt_pkg::t_req r_in_req;
    logic          r_out_valid;
    wdt_pkg::t_rsp r_out_rsp;

    logic          advance;
    wdt_pkg::t_rsp n_rsp;

    assign advance     = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.ready && i_req.valid) begin
            r_in_req.operation  <= i_req.operation;
            r_in_req.reg_select <= i_req.reg_select;
            r_in_req.write_data <= i_req.write_data;
        end
    end

    wdt_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (advance),
        .i_req   (r_in_req),
        .o_rsp   (n_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_rsp <= n_rsp;
        end
    end

    assign o_rsp.valid             = r_out_valid;
    assign o_rsp.read_data         = r_out_rsp.read_data;
    assign o_rsp.early_warning_irq = r_out_rsp.early_warning_irq;
    assign o_rsp.system_reset      = r_out_rsp.system_reset;

    // only a tick can fire the system reset
    a_reset_only_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && (r_in_req.operation != wdt_pkg::OP_TICK)) |-> !n_rsp.system_reset)
        else $error("system reset raised by a non-tick request");

    // a request that moves on always lands in the output register
    a_advance_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("response lost after advancing");

    // a held request keeps its payload until it moves on
    a_hold_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_in_req)))
        else $error("pending request dropped or changed");

    // read data is zero unless the request was a read
    a_read_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && (r_in_req.operation != wdt_pkg::OP_READ)) |-> (n_rsp.read_data == 8'd0))
        else $error("read data driven on a non-read request");

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;

    localparam logic [1:0] OP_NONE = 2'd3;
    localparam int unsigned RANDOM_REQUESTS = 1150;

    logic i_clk;
    logic i_rst_n;

    wdt_req_if req_bus ();
    wdt_rsp_if rsp_bus ();

    watchdog_timer_early_warning DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    // Own copy of the watchdog state
    logic                           wd_running;
    logic                           wd_window;
    logic [3:0]                     wd_period_code;
    logic [3:0]                     wd_warn_code;
    logic                           wd_irq_en;
    logic                           wd_flag;
    logic [wdt_pkg::CountWidth-1:0] wd_count;

    wdt_pkg::t_rsp due_rsp[$];
    int unsigned   mismatch_count;
    int unsigned   requests_sent;
    bit            gaps_on;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    // Codes above ten saturate at the maximum
    function automatic logic [wdt_pkg::CountWidth-1:0] cycles_for(logic [3:0] code);
        if (code >= wdt_pkg::CODE_SATURATE) begin
            return wdt_pkg::MAX_CYCLES;
        end
        return wdt_pkg::MAX_CYCLES >> (wdt_pkg::CODE_SATURATE - code);
    endfunction

    function automatic wdt_pkg::t_rsp watchdog_step(logic [1:0] op, logic [2:0] sel,
                                                    logic [7:0] data);
        wdt_pkg::t_rsp r;
        r = '0;
        if (op == wdt_pkg::OP_TICK) begin
            if (wd_running) begin
                wd_count = wd_count + 1'b1;
                if (wd_count == cycles_for(wd_warn_code)) begin
                    wd_flag = 1'b1;
                end
                if (wd_count >= cycles_for(wd_period_code)) begin
                    r.system_reset = 1'b1;
                    wd_count = '0;
                end
            end
        end else if (op == wdt_pkg::OP_WRITE) begin
            case (sel)
                wdt_pkg::SEL_CTRL: begin
                    wd_running = data[0];
                    wd_window = data[1];
                end
                wdt_pkg::SEL_PERIOD: wd_period_code = data[3:0];
                wdt_pkg::SEL_EWOFFSET: wd_warn_code = data[3:0];
                wdt_pkg::SEL_INTSET: if (data[0]) wd_irq_en = 1'b1;
                wdt_pkg::SEL_INTCLR: if (data[0]) wd_irq_en = 1'b0;
                wdt_pkg::SEL_FLAG: if (data[0]) wd_flag = 1'b0;
                wdt_pkg::SEL_CLEAR: if (data == wdt_pkg::CLEAR_KEY) wd_count = '0;
                default: ;
            endcase
        end else if (op == wdt_pkg::OP_READ) begin
            case (sel)
                wdt_pkg::SEL_CTRL: r.read_data = {6'd0, wd_window, wd_running};
                wdt_pkg::SEL_PERIOD: r.read_data = {4'd0, wd_period_code};
                wdt_pkg::SEL_EWOFFSET: r.read_data = {4'd0, wd_warn_code};
                wdt_pkg::SEL_INTSET, wdt_pkg::SEL_INTCLR: r.read_data = {7'd0, wd_irq_en};
                wdt_pkg::SEL_FLAG: r.read_data = {7'd0, wd_flag};
                default: r.read_data = 8'd0;
            endcase
        end
        r.early_warning_irq = wd_flag & wd_irq_en;
        return r;
    endfunction

    task automatic send_request(logic [1:0] op, logic [2:0] sel, logic [7:0] data);
        while (gaps_on && $urandom_range(99) < 32) begin
            req_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_bus.valid <= 1'b1;
        req_bus.operation <= op;
        req_bus.reg_select <= sel;
        req_bus.write_data <= data;
        do begin
            @(posedge i_clk);
        end while (!req_bus.ready);
        due_rsp.push_back(watchdog_step(op, sel, data));
        requests_sent++;
    endtask

    task automatic write_reg(logic [2:0] sel, logic [7:0] data);
        send_request(wdt_pkg::OP_WRITE, sel, data);
    endtask

    task automatic read_reg(logic [2:0] sel);
        send_request(wdt_pkg::OP_READ, sel, 8'($urandom));
    endtask

    task automatic tick(int unsigned n);
        repeat (n) send_request(wdt_pkg::OP_TICK, 3'($urandom), 8'($urandom));
    endtask

    task automatic read_all();
        for (int s = 0; s < 8; s++) begin
            read_reg(3'(s));
        end
    endtask

    // Hold the sender until every response is back
    task automatic drain();
        req_bus.valid <= 1'b0;
        while (due_rsp.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic test_register_access();
        read_all();
        write_reg(wdt_pkg::SEL_CTRL, 8'hFE);
        read_reg(wdt_pkg::SEL_CTRL);
        write_reg(wdt_pkg::SEL_CTRL, 8'h00);
        write_reg(wdt_pkg::SEL_PERIOD, 8'hF0);
        read_reg(wdt_pkg::SEL_PERIOD);
        write_reg(wdt_pkg::SEL_PERIOD, 8'h0F);
        write_reg(wdt_pkg::SEL_EWOFFSET, 8'hFF);
        read_reg(wdt_pkg::SEL_EWOFFSET);
        write_reg(wdt_pkg::SEL_INTSET, 8'hFE);
        read_reg(wdt_pkg::SEL_INTSET);
        write_reg(wdt_pkg::SEL_INTSET, 8'h01);
        read_reg(wdt_pkg::SEL_INTCLR);
        write_reg(wdt_pkg::SEL_INTCLR, 8'hFE);
        write_reg(wdt_pkg::SEL_INTCLR, 8'hFF);
        write_reg(wdt_pkg::SEL_STATUS, 8'hFF);
        send_request(OP_NONE, wdt_pkg::SEL_CTRL, 8'hFF);
        send_request(OP_NONE, wdt_pkg::SEL_PERIOD, 8'h00);
        read_all();
    endtask

    task automatic test_special_cases();
        drain();
        // Warning before the period, interrupt enabled
        write_reg(wdt_pkg::SEL_PERIOD, 8'h01);
        write_reg(wdt_pkg::SEL_EWOFFSET, 8'h00);
        write_reg(wdt_pkg::SEL_INTSET, 8'h01);
        write_reg(wdt_pkg::SEL_CTRL, 8'h01);
        tick(16);
        read_reg(wdt_pkg::SEL_FLAG);
        write_reg(wdt_pkg::SEL_FLAG, 8'hFE);
        write_reg(wdt_pkg::SEL_FLAG, 8'h01);
        // Wrong key is ignored, right key restarts the count
        tick(5);
        write_reg(wdt_pkg::SEL_CLEAR, 8'h5A);
        tick(5);
        write_reg(wdt_pkg::SEL_CLEAR, wdt_pkg::CLEAR_KEY);
        tick(16);
        // Disabled counter holds, window bit alone does not count
        write_reg(wdt_pkg::SEL_CTRL, 8'h02);
        tick(20);
        read_reg(wdt_pkg::SEL_CTRL);
        write_reg(wdt_pkg::SEL_CTRL, 8'h01);
        tick(3);
        // Period lowered below the count fires on the next tick
        write_reg(wdt_pkg::SEL_PERIOD, 8'h04);
        tick(40);
        write_reg(wdt_pkg::SEL_PERIOD, 8'h00);
        tick(2);
        // Offset beyond the period never warns; equal warns with the reset
        write_reg(wdt_pkg::SEL_FLAG, 8'h01);
        write_reg(wdt_pkg::SEL_EWOFFSET, 8'h03);
        write_reg(wdt_pkg::SEL_PERIOD, 8'h01);
        tick(40);
        write_reg(wdt_pkg::SEL_EWOFFSET, 8'h01);
        write_reg(wdt_pkg::SEL_CLEAR, wdt_pkg::CLEAR_KEY);
        tick(16);
        write_reg(wdt_pkg::SEL_INTCLR, 8'h01);
        read_all();
    endtask

    task automatic test_full_period();
        gaps_on = 1'b0;
        write_reg(wdt_pkg::SEL_CTRL, 8'h00);
        write_reg(wdt_pkg::SEL_PERIOD, 8'h05);
        write_reg(wdt_pkg::SEL_EWOFFSET, 8'h04);
        write_reg(wdt_pkg::SEL_INTSET, 8'h01);
        write_reg(wdt_pkg::SEL_FLAG, 8'h01);
        write_reg(wdt_pkg::SEL_CLEAR, wdt_pkg::CLEAR_KEY);
        write_reg(wdt_pkg::SEL_CTRL, 8'h03);
        tick(260);
        // Saturated period code must not wrap to a short period
        write_reg(wdt_pkg::SEL_FLAG, 8'h01);
        write_reg(wdt_pkg::SEL_CLEAR, wdt_pkg::CLEAR_KEY);
        write_reg(wdt_pkg::SEL_PERIOD, 8'h0F);
        write_reg(wdt_pkg::SEL_EWOFFSET, 8'h00);
        tick(12);
        read_all();
        gaps_on = 1'b1;
    endtask

    task automatic test_random_sessions();
        int unsigned burst;
        int unsigned pick;
        logic [7:0]  data;
        bit          paused;
        paused = 1'b0;
        requests_sent = 0;
        while (requests_sent < RANDOM_REQUESTS) begin
            if (!paused && requests_sent > RANDOM_REQUESTS / 2) begin
                drain();
                paused = 1'b1;
            end
            if ($urandom_range(9) < 7) begin
                // Well-formed session: configure, enable, then mostly ticks
                data = 8'($urandom);
                data[3:0] = ($urandom_range(9) == 0) ? 4'($urandom) : 4'($urandom_range(4));
                write_reg(wdt_pkg::SEL_PERIOD, data);
                data = 8'($urandom);
                data[3:0] = ($urandom_range(9) == 0) ? 4'($urandom) : 4'($urandom_range(5));
                write_reg(wdt_pkg::SEL_EWOFFSET, data);
                write_reg($urandom_range(1) ? wdt_pkg::SEL_INTSET : wdt_pkg::SEL_INTCLR,
                          8'($urandom));
                data = 8'($urandom);
                data[0] = ($urandom_range(9) != 0);
                write_reg(wdt_pkg::SEL_CTRL, data);
                burst = $urandom_range(1, 80);
                repeat (burst) begin
                    pick = $urandom_range(99);
                    if (pick < 85) begin
                        tick(1);
                    end else if (pick < 90) begin
                        read_reg(3'($urandom));
                    end else if (pick < 93) begin
                        write_reg(wdt_pkg::SEL_CLEAR,
                                  $urandom_range(3) == 0 ? 8'($urandom) : wdt_pkg::CLEAR_KEY);
                    end else if (pick < 97) begin
                        write_reg(wdt_pkg::SEL_FLAG, 8'($urandom));
                    end else begin
                        write_reg(3'($urandom), 8'($urandom));
                    end
                end
            end else begin
                repeat ($urandom_range(1, 10)) begin
                    send_request(2'($urandom), 3'($urandom), 8'($urandom));
                end
            end
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        req_bus.valid <= 1'b0;
        req_bus.operation <= wdt_pkg::OP_TICK;
        req_bus.reg_select <= wdt_pkg::SEL_CTRL;
        req_bus.write_data <= 8'd0;
        wd_running = 1'b0;
        wd_window = 1'b0;
        wd_period_code = wdt_pkg::CODE_RESET;
        wd_warn_code = wdt_pkg::CODE_RESET;
        wd_irq_en = 1'b0;
        wd_flag = 1'b0;
        wd_count = '0;
        mismatch_count = 0;
        requests_sent = 0;
        gaps_on = 1'b1;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_register_access();
        test_special_cases();
        test_full_period();
        test_random_sessions();

        drain();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Response side: random stalls, compare against the oldest prediction
    initial begin
        wdt_pkg::t_rsp want;
        rsp_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && rsp_bus.valid && rsp_bus.ready) begin
                if (due_rsp.size() == 0) begin
                    $display("%0t: response with none outstanding: read_data %h irq %b sysrst %b",
                             $time, rsp_bus.read_data, rsp_bus.early_warning_irq,
                             rsp_bus.system_reset);
                    mismatch_count++;
                end else begin
                    want = due_rsp.pop_front();
                    if (rsp_bus.read_data !== want.read_data) begin
                        $display("%0t: read_data expected %h actual %h",
                                 $time, want.read_data, rsp_bus.read_data);
                        mismatch_count++;
                    end
                    if (rsp_bus.early_warning_irq !== want.early_warning_irq) begin
                        $display("%0t: early_warning_irq expected %b actual %b",
                                 $time, want.early_warning_irq, rsp_bus.early_warning_irq);
                        mismatch_count++;
                    end
                    if (rsp_bus.system_reset !== want.system_reset) begin
                        $display("%0t: system_reset expected %b actual %b",
                                 $time, want.system_reset, rsp_bus.system_reset);
                        mismatch_count++;
                    end
                end
            end
            rsp_bus.ready <= !(gaps_on && $urandom_range(99) < 32);
        end
    end

endmodule
